FILE: hdl/arena_bump_allocator_unit_assert.svh
// Assertion macros for the arena bump allocator.
// Uses i_clk and i_rst_n of the including module; no other dependencies.
`ifndef ARENA_BUMP_ALLOCATOR_UNIT_ASSERT_SVH
`define ARENA_BUMP_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ABAU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ABAU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ABAU_ASSERT_IMP(label, ante, cons, msg)
`define ABAU_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

FILE: hdl/abau_pkg.sv
// Shared types and constants for the arena bump allocator.
// No dependencies.
`timescale 1ns / 1ps

package abau_pkg;

    localparam int unsigned ARENA_BYTES = 65536;
    localparam int unsigned LEN_W       = 17;
    localparam int unsigned OFS_W       = 16;
    localparam int unsigned BASE_W      = 12;
    localparam int unsigned ALIGN_W     = 4;
    localparam int unsigned MAX_ALIGN   = 12;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned IN_DATA_W   = 56;
    localparam int unsigned IN_USER_W   = 2;
    localparam int unsigned OUT_DATA_W  = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARENA_CAPACITY = 1'b0,
        CFG_BASE_LOW_BITS  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_REALLOC = 2'd1,
        KIND_FREE    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]         kind;
        logic [LEN_W-1:0]   request_size;
        logic [LEN_W-1:0]   prior_size;
        logic [ALIGN_W-1:0] align_log2;
        logic [OFS_W-1:0]   block_offset;
    } t_request;

    typedef struct packed {
        logic             granted;
        logic [OFS_W-1:0] result_offset;
        logic             moved;
        logic [LEN_W-1:0] length_after;
    } t_result;

endpackage

FILE: hdl/arena_bump_allocator_unit.sv
// Arena bump allocator top level: request register, evaluation, result register.
// Depends on abau_pkg, abau_calc and arena_bump_allocator_unit_assert.svh.
//
// Usage:
//   Requests enter on the s_axis channel: s_axis_tuser carries the kind
//   (allocate, reallocate, free), s_axis_tdata the sizes, alignment and block
//   offset. Each request yields exactly one result on m_axis: granted, offset,
//   moved flag and the used length after the request.
//   Throughput is one request per cycle while m_axis_tready is high: a request
//   is evaluated in a single pass against the used-length register, which
//   updates in the same cycle the result registers. Registers arena_capacity
//   (index 0) and base_low_bits (index 1) are written through i_cfg_we,
//   i_cfg_index and i_cfg_data; the user must write them only while no request
//   is in flight, which the block does not enforce. Reset clears the used
//   length, empties both stages and restores capacity 65536 and base bits 0.
//   When m_axis_tready is low the result holds, one more request is still taken
//   into the input register, then s_axis_tready drops.
`timescale 1ns / 1ps
`include "arena_bump_allocator_unit_assert.svh"

module arena_bump_allocator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [16:0] request_size, [33:17] prior_size, [37:34] align_log2,
    // [53:38] block_offset, [55:54] zero
    input  logic [abau_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] kind
    input  logic [abau_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] granted, [16:1] result_offset, [17] moved, [34:18] length_after,
    // [39:35] zero
    output logic [abau_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [abau_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [abau_pkg::LEN_W-1:0]         i_cfg_data
);
    import abau_pkg::*;

    logic             r_in_valid;
    t_request         r_req;
    logic             r_out_valid;
    t_result          r_res;
    logic [LEN_W-1:0] r_used;
    logic [LEN_W-1:0] r_capacity;
    logic [BASE_W-1:0] r_base;

    t_result calc_res;
    logic    advance;
    logic    s_fire;
    logic    refused;
    logic    in_hold;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign refused       = advance && !calc_res.granted;
    assign in_hold       = r_in_valid && !advance;

    abau_calc u_calc (
        .i_req      (r_req),
        .i_used     (r_used),
        .i_capacity (r_capacity),
        .i_base     (r_base),
        .o_res      (calc_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_req.kind         <= s_axis_tuser;
            r_req.request_size <= s_axis_tdata[16:0];
            r_req.prior_size   <= s_axis_tdata[33:17];
            r_req.align_log2   <= s_axis_tdata[37:34];
            r_req.block_offset <= s_axis_tdata[53:38];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_used      <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_used      <= calc_res.length_after;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= calc_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= LEN_W'(ARENA_BYTES);
            r_base     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ARENA_CAPACITY: r_capacity <= i_cfg_data;
                CFG_BASE_LOW_BITS:  r_base     <= i_cfg_data[BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_res.length_after, r_res.moved,
                            r_res.result_offset, r_res.granted};

    `ABAU_ASSERT_IMP(a_used_bound, 1'b1, r_used <= LEN_W'(ARENA_BYTES), "used length too large")
    `ABAU_ASSERT_NXT(a_refuse_keeps, refused, r_used == $past(r_used), "refusal changed length")
    `ABAU_ASSERT_IMP(a_moved_granted, r_out_valid && r_res.moved, r_res.granted, "moved w/o grant")
    `ABAU_ASSERT_NXT(a_hold_request, in_hold, r_in_valid && $stable(r_req), "request lost")

endmodule

FILE: hdl/abau_calc.sv
// Request evaluation for the arena bump allocator: padding, free space,
// placement decision and next used length. Depends on abau_pkg.
`timescale 1ns / 1ps

module abau_calc (
    input  abau_pkg::t_request           i_req,
    input  logic [abau_pkg::LEN_W-1:0]   i_used,
    input  logic [abau_pkg::LEN_W-1:0]   i_capacity,
    input  logic [abau_pkg::BASE_W-1:0]  i_base,
    output abau_pkg::t_result            o_res
);
    import abau_pkg::*;

    localparam logic [LEN_W-1:0] CAP_MAX = LEN_W'(ARENA_BYTES);

    logic [ALIGN_W-1:0] al;
    logic [BASE_W-1:0]  mask;
    logic [BASE_W-1:0]  addr_low;
    logic [BASE_W-1:0]  pad;
    logic [LEN_W-1:0]   cap;
    logic signed [19:0] s_used, s_pad, s_cap, s_size, s_old, s_blk;
    logic signed [19:0] avail, diff, top, top_end;
    logic               at_top;

    always_comb begin
        al       = (i_req.align_log2 > ALIGN_W'(MAX_ALIGN)) ? ALIGN_W'(MAX_ALIGN)
                                                             : i_req.align_log2;
        mask     = BASE_W'((13'd1 << al) - 13'd1);
        addr_low = i_base + i_used[BASE_W-1:0];
        pad      = (BASE_W'(0) - addr_low) & mask;
        cap      = (i_capacity > CAP_MAX) ? CAP_MAX : i_capacity;

        s_used = signed'({3'b000, i_used});
        s_pad  = signed'({8'd0, pad});
        s_cap  = signed'({3'b000, cap});
        s_size = signed'({3'b000, i_req.request_size});
        s_old  = signed'({3'b000, i_req.prior_size});
        s_blk  = signed'({4'd0, i_req.block_offset});

        avail   = s_cap - s_used - s_pad;
        diff    = s_size - s_old;
        top     = s_used + s_pad;
        top_end = top + s_size;
        at_top  = (s_used - s_old) == s_blk;

        o_res.granted       = 1'b0;
        o_res.result_offset = '0;
        o_res.moved         = 1'b0;
        o_res.length_after  = i_used;

        unique case (t_kind'(i_req.kind))
            KIND_ALLOC: begin
                if (!(s_size > avail)) begin
                    o_res.granted       = 1'b1;
                    o_res.result_offset = top[OFS_W-1:0];
                    o_res.length_after  = top_end[LEN_W-1:0];
                end
            end
            KIND_REALLOC: begin
                priority if (diff == 20'sd0) begin
                    o_res.granted       = 1'b1;
                    o_res.result_offset = i_req.block_offset;
                end else if (at_top) begin
                    if (!(diff > 20'sd0 && avail < diff)) begin
                        o_res.granted       = 1'b1;
                        o_res.result_offset = i_req.block_offset;
                        o_res.length_after  = LEN_W'(s_used + diff);
                    end
                end else if (diff < 20'sd0) begin
                    o_res.granted       = 1'b1;
                    o_res.result_offset = i_req.block_offset;
                end else if (!(avail < s_size)) begin
                    o_res.granted       = 1'b1;
                    o_res.result_offset = top[OFS_W-1:0];
                    o_res.moved         = 1'b1;
                    o_res.length_after  = top_end[LEN_W-1:0];
                end
            end
            KIND_FREE: begin
                o_res.granted = 1'b1;
                if (s_blk == s_used - s_size) begin
                    o_res.length_after = LEN_W'(s_used - s_size);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: dv/arena_bump_allocator_unit_tb.sv
// Self-checking testbench for arena_bump_allocator_unit: random and directed requests,
// random idling on both streams, and a scoreboard that predicts every result.
// Depends on abau_pkg and the arena_bump_allocator_unit RTL.
`timescale 1ns / 1ps

module arena_bump_allocator_unit_tb;
    import abau_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 305;
    localparam int LONG_HOLD   = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 4;

    class alloc_scoreboard;
        logic [LEN_W-1:0]  used_len;
        logic [LEN_W-1:0]  capacity;
        logic [BASE_W-1:0] base_bits;
        t_result           expected_grants[$];
        int                errors;
        int                results;
        int                grants;
        int                refusals;
        int                moves;
        int                kind_count[4];

        function new();
            used_len  = '0;
            capacity  = LEN_W'(ARENA_BYTES);
            base_bits = '0;
            errors    = 0;
            results   = 0;
            grants    = 0;
            refusals  = 0;
            moves     = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function void set_config(logic [LEN_W-1:0] cap, logic [BASE_W-1:0] base);
            capacity  = cap;
            base_bits = base;
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction

        // predict the outcome of one accepted request and advance the used length
        function void note_request(logic [1:0] kind, logic [LEN_W-1:0] size,
                                   logic [LEN_W-1:0] old, logic [ALIGN_W-1:0] al,
                                   logic [OFS_W-1:0] blk);
            longint  sz, od, bk, used, pad, avail, diff, cap_eff;
            int      al_eff;
            t_result r;
            sz      = size;
            od      = old;
            bk      = blk;
            used    = used_len;
            al_eff  = (al > MAX_ALIGN) ? MAX_ALIGN : al;
            cap_eff = (capacity > ARENA_BYTES) ? ARENA_BYTES : capacity;
            pad     = (-(longint'(base_bits) + used)) & ((longint'(1) << al_eff) - 1);
            avail   = cap_eff - used - pad;
            r       = '0;
            kind_count[kind]++;
            case (kind)
                KIND_ALLOC: begin
                    if (sz <= avail) begin
                        r.granted       = 1'b1;
                        r.result_offset = OFS_W'(used + pad);
                        used            = used + pad + sz;
                    end
                end
                KIND_REALLOC: begin
                    diff = sz - od;
                    if (diff == 0) begin
                        r.granted       = 1'b1;
                        r.result_offset = blk;
                    end else if (used - od == bk) begin
                        if (!(diff > 0 && avail < diff)) begin
                            r.granted       = 1'b1;
                            r.result_offset = blk;
                            used            = used + diff;
                        end
                    end else if (diff < 0) begin
                        r.granted       = 1'b1;
                        r.result_offset = blk;
                    end else if (avail >= sz) begin
                        r.granted       = 1'b1;
                        r.result_offset = OFS_W'(used + pad);
                        r.moved         = 1'b1;
                        used            = used + pad + sz;
                    end
                end
                KIND_FREE: begin
                    r.granted = 1'b1;
                    if (bk == used - sz) used = used - sz;
                end
                default: ;
            endcase
            used_len       = LEN_W'(used);
            r.length_after = used_len;
            expected_grants.push_back(r);
        endfunction

        function void check_grant(logic [OUT_DATA_W-1:0] d);
            t_result e;
            if (expected_grants.size() == 0) begin
                $error("unexpected result: data 0x%0h", d);
                errors++;
                return;
            end
            e = expected_grants.pop_front();
            results++;
            if (e.granted) grants++;
            else refusals++;
            if (e.moved) moves++;
            if (d[0] !== e.granted) begin
                $error("granted: expected %0d, actual %0d", e.granted, d[0]);
                errors++;
            end
            if (d[16:1] !== e.result_offset) begin
                $error("result_offset: expected %0d, actual %0d", e.result_offset, d[16:1]);
                errors++;
            end
            if (d[17] !== e.moved) begin
                $error("moved: expected %0d, actual %0d", e.moved, d[17]);
                errors++;
            end
            if (d[34:18] !== e.length_after) begin
                $error("length_after: expected %0d, actual %0d", e.length_after, d[34:18]);
                errors++;
            end
        endfunction

        function void close_out();
            if (expected_grants.size() != 0) begin
                $error("%0d results never arrived", expected_grants.size());
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [16:0] request_size, [33:17] prior_size, [37:34] align_log2,
    // [53:38] block_offset, [55:54] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // [1:0] kind
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] granted, [16:1] result_offset, [17] moved, [34:18] length_after, [39:35] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_ARENA_CAPACITY;
    logic [LEN_W-1:0]      i_cfg_data    = '0;

    alloc_scoreboard sb;
    int              sent_count   = 0;
    int              stall_cycles = 0;
    int              settings     = 1;

    arena_bump_allocator_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_grant(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off
    initial begin : result_sink
        int unsigned r;
        int unsigned n;
        bit          long_hold_done;
        long_hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!long_hold_done && sb.results >= 300) begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_axis_tready <= 1'b1;
                    n = $urandom_range(1, 40);
                end else begin
                    m_axis_tready <= 1'b0;
                    n = (r < 88) ? $urandom_range(1, 3) :
                        (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 60);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic sender_gap();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        n = (r < 55) ? 0 : (r < 85) ? $urandom_range(1, 3) :
            (r < 97) ? $urandom_range(4, 10) : $urandom_range(15, 40);
        if ((sent_count / 32) % 4 == 0) n = 0;
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_request(logic [1:0] kind, logic [LEN_W-1:0] size,
                                logic [LEN_W-1:0] old, logic [ALIGN_W-1:0] al,
                                logic [OFS_W-1:0] blk);
        sender_gap();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, blk, al, old, size};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(kind, size, old, al, blk);
        sent_count++;
    endtask

    function automatic logic [LEN_W-1:0] rand_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return LEN_W'($urandom_range(0, 256));
        if (r < 95) return LEN_W'($urandom_range(257, 4096));
        if (r < 99) return LEN_W'($urandom_range(4097, 65536));
        return LEN_W'($urandom_range(0, 131071));
    endfunction

    function automatic logic [ALIGN_W-1:0] rand_align();
        if ($urandom_range(0, 9) == 0) return ALIGN_W'($urandom_range(13, 15));
        return ALIGN_W'($urandom_range(0, 12));
    endfunction

    task automatic send_random();
        int unsigned      r;
        int unsigned      used;
        int unsigned      od_max;
        logic [1:0]       kind;
        logic [LEN_W-1:0] size;
        logic [LEN_W-1:0] old;
        logic [OFS_W-1:0] blk;
        r    = $urandom_range(0, 99);
        used = sb.used_len;
        size = rand_size();
        old  = rand_size();
        blk  = OFS_W'($urandom_range(0, 65535));
        if (r < 35) begin
            kind = KIND_ALLOC;
        end else if (r < 55) begin
            // resize the block that ends at the top
            kind   = KIND_REALLOC;
            od_max = (used < 2000) ? used : 2000;
            old    = LEN_W'($urandom_range(0, od_max));
            if ($urandom_range(0, 4) == 0) size = old;
            blk    = OFS_W'(used - old);
        end else if (r < 65) begin
            kind = KIND_REALLOC;
        end else if (r < 85) begin
            // release the top block, sometimes the whole arena
            kind = KIND_FREE;
            size = ($urandom_range(0, 9) == 0) ? LEN_W'(used) :
                   LEN_W'($urandom_range(0, (used < 700) ? used : 700));
            blk  = OFS_W'(used - size);
        end else if (r < 92) begin
            kind = KIND_FREE;
        end else if (r < 95) begin
            kind = KIND_UNUSED;
        end else begin
            kind = 2'($urandom_range(0, 3));
            size = LEN_W'($urandom_range(0, 131071));
            old  = LEN_W'($urandom_range(0, 131071));
        end
        send_request(kind, size, old, rand_align(), blk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_config(logic [LEN_W-1:0] cap, logic [BASE_W-1:0] base);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ARENA_CAPACITY;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        i_cfg_index <= CFG_BASE_LOW_BITS;
        i_cfg_data  <= LEN_W'(base);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_config(cap, base);
        settings++;
    endtask

    task automatic run_directed();
        send_request(KIND_ALLOC,   17'd0,      17'd0,      4'd0,  16'd0);
        send_request(KIND_ALLOC,   17'd65536,  17'd0,      4'd0,  16'd0);
        // zero-size block at offset 65536
        send_request(KIND_ALLOC,   17'd0,      17'd0,      4'd0,  16'd0);
        send_request(KIND_ALLOC,   17'd1,      17'd0,      4'd0,  16'd0);
        send_request(KIND_REALLOC, 17'd65536,  17'd65536,  4'd0,  16'd0);
        send_request(KIND_REALLOC, 17'd100,    17'd65536,  4'd0,  16'd0);
        send_request(KIND_REALLOC, 17'd200,    17'd100,    4'd3,  16'd0);
        send_request(KIND_ALLOC,   17'd3,      17'd0,      4'd15, 16'd0);
        send_request(KIND_REALLOC, 17'd50,     17'd10,     4'd4,  16'd7);
        send_request(KIND_REALLOC, 17'd5,      17'd10,     4'd12, 16'd7);
        send_request(KIND_REALLOC, 17'd70000,  17'd50,     4'd0,  16'd4112);
        send_request(KIND_FREE,    17'd50,     17'd0,      4'd0,  16'd4112);
        send_request(KIND_FREE,    17'd5,      17'd0,      4'd0,  16'd9);
        send_request(KIND_UNUSED,  17'h1FFFF,  17'h1FFFF,  4'hF,  16'hFFFF);
        send_request(KIND_REALLOC, 17'h1FFFF,  17'd0,      4'd13, 16'hFFFF);
        send_request(KIND_FREE,    17'd4112,   17'h1FFFF,  4'd0,  16'd0);
        send_request(KIND_ALLOC,   17'h1FFFF,  17'd0,      4'd0,  16'd0);
        send_request(KIND_ALLOC,   17'd4000,   17'd0,      4'd7,  16'd0);
        send_request(KIND_ALLOC,   17'd61000,  17'd0,      4'd0,  16'd0);
    endtask

    initial begin : stimulus
        logic [LEN_W-1:0]  cap;
        logic [BASE_W-1:0] base;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin cap = 17'd65536; base = 12'd4095; end
                1: begin cap = 17'd0;     base = 12'd0;    end  // everything below used
                2: begin cap = 17'h1FFFF; base = 12'd1;    end
                3: begin cap = 17'd300;   base = BASE_W'($urandom_range(0, 4095)); end
                4: begin
                    cap  = LEN_W'($urandom_range(0, 65536));
                    base = BASE_W'($urandom_range(0, 4095));
                end
                default: begin cap = 17'd65536; base = 12'd0; end
            endcase
            drain();
            set_config(cap, base);
            repeat (PHASE_ITEMS) send_random();
        end
        drain();
        repeat (8) @(posedge i_clk);
        sb.close_out();
        $display("Sent %0d requests (alloc %0d, realloc %0d, free %0d, unused kind %0d)",
                 sent_count, sb.kind_count[0], sb.kind_count[1], sb.kind_count[2],
                 sb.kind_count[3]);
        $display("Across %0d register settings: %0d granted, %0d refused, %0d moved",
                 settings, sb.grants, sb.refusals, sb.moves);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/abau_pkg.sv
hdl/abau_calc.sv
hdl/arena_bump_allocator_unit.sv
dv/arena_bump_allocator_unit_tb.sv
